### rtl/sorted_priority_queue_core_assert.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Clocked, reset-gated property wrappers shared by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define SPQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, codes and sizes for the queue cells and top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 64;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned ENTRY_COUNT_W    = 7;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CHANGE = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_EMPTY   = 2'd2,
    STATUS_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_op_e;

  typedef enum logic {
    ST_IDLE     = 1'b0,
    ST_REINSERT = 1'b1
  } spq_state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   item;
  } cell_ctrl_t;

endpackage

### rtl/spq_req_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue request channel
// Valid/ready channel carrying one queue request per transfer.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic signed [31:0] item_value;
  logic signed [31:0] item_priority;

  modport source (
    output valid, req_type, item_value, item_priority,
    input  ready
  );

  modport sink (
    input  valid, req_type, item_value, item_priority,
    output ready
  );
endinterface

### rtl/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue response channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [6:0]         entry_count;
  logic               head_valid;
  logic signed [31:0] head_value;
  logic signed [31:0] head_priority;

  modport source (
    output valid, status, entry_count, head_valid, head_value, head_priority,
    input  ready
  );

  modport sink (
    input  valid, status, entry_count, head_valid, head_value, head_priority,
    output ready
  );
endinterface

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: compares against the broadcast item and
// takes its own, its left neighbor's, its right neighbor's or the new entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic               occ_i,
  input  logic               shift_i,
  input  spq_pkg::entry_t    left_i,
  input  logic               left_ge_i,
  input  spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t    entry_o,
  output spq_pkg::entry_t    next_o,
  output logic               ge_o,
  output logic               match_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;
  logic   ge;

  assign ge      = occ_i && !($signed(entry_q.prio) < $signed(ctrl_i.item.prio));
  assign ge_o    = ge;
  assign match_o = occ_i && (entry_q.value == ctrl_i.item.value);
  assign entry_o = entry_q;
  assign next_o  = entry_d;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (!ge) begin
          entry_d = left_ge_i ? ctrl_i.item : left_i;
        end
      end
      CELL_SHIFT: begin
        if (shift_i) begin
          entry_d = right_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Insert, remove, unknown and unmatched change requests give a registered
// result in the cycle after the transfer; a matched change shifts out, then
// shifts back in from ST_REINSERT before its result is registered.
// Throughput: 1 request per cycle in ST_IDLE with the output free or read.
// Reset clears the entry count and output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_core_assert.svh"

module sorted_priority_queue_core #(
  parameter int unsigned CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_req_if.sink    req_i,
  spq_rsp_if.source  rsp_o
);
  import spq_pkg::*;

  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  spq_state_e          state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  entry_t              pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic                load_out;
  status_e             status_d;
  logic [1:0]          out_status_q;
  logic [6:0]          out_count_q;
  logic                out_head_valid_q;
  logic signed [31:0]  out_head_value_q;
  logic signed [31:0]  out_head_prio_q;

  cell_ctrl_t          ctrl;
  logic                accept;
  logic                found;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] ge_vec;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] first_hit;
  logic [CAPACITY-1:0] first_mask;
  logic [CAPACITY-1:0] shift_vec;
  logic [CAPACITY-2:0] order_ok;
  entry_t              cell_q    [CAPACITY];
  entry_t              cell_next [CAPACITY];

  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign found       = |match_vec;
  assign first_hit   = match_vec & (~match_vec + CAPACITY'(1));
  assign first_mask  = ~first_hit + CAPACITY'(1);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_ge;

    assign occ[i] = CountW'(i) < count_q;

    if (i == 0) begin : g_first
      assign left_e  = '0;
      assign left_ge = 1'b1;
    end else begin : g_mid
      assign left_e  = cell_q[i-1];
      assign left_ge = ge_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .occ_i     (occ[i]),
      .shift_i   (shift_vec[i]),
      .left_i    (left_e),
      .left_ge_i (left_ge),
      .right_i   (right_e),
      .entry_o   (cell_q[i]),
      .next_o    (cell_next[i]),
      .ge_o      (ge_vec[i]),
      .match_o   (match_vec[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.req_type == REQ_CHANGE) && found) begin
          state_d = ST_REINSERT;
        end
      end
      ST_REINSERT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.op         = CELL_HOLD;
    ctrl.item.value = req_i.item_value;
    ctrl.item.prio  = req_i.item_priority;
    shift_vec       = '1;
    count_d         = count_q;
    pend_d          = pend_q;
    load_out        = 1'b0;
    status_d        = STATUS_DONE;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pend_d = ctrl.item;
          case (req_i.req_type)
            REQ_INSERT: begin
              load_out = 1'b1;
              if (count_q == CountW'(CAPACITY)) begin
                status_d = STATUS_FULL;
              end else begin
                ctrl.op = CELL_INSERT;
                count_d = count_q + CountW'(1);
              end
            end
            REQ_REMOVE: begin
              load_out = 1'b1;
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
              end else begin
                ctrl.op = CELL_SHIFT;
                count_d = count_q - CountW'(1);
              end
            end
            REQ_CHANGE: begin
              if (found) begin
                ctrl.op   = CELL_SHIFT;
                shift_vec = first_mask;
                count_d   = count_q - CountW'(1);
              end else begin
                load_out = 1'b1;
                status_d = STATUS_MISSING;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_REINSERT: begin
        ctrl.op   = CELL_INSERT;
        ctrl.item = pend_q;
        count_d   = count_q + CountW'(1);
        load_out  = 1'b1;
      end
      default: begin
        ctrl.op = CELL_HOLD;
      end
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (load_out) begin
      out_status_q     <= status_d;
      out_count_q      <= ENTRY_COUNT_W'(count_d);
      out_head_valid_q <= (count_d != '0);
      out_head_value_q <= (count_d != '0) ? cell_next[0].value : '0;
      out_head_prio_q  <= (count_d != '0) ? cell_next[0].prio : '0;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.entry_count   = out_count_q;
  assign rsp_o.head_valid    = out_head_valid_q;
  assign rsp_o.head_value    = out_head_value_q;
  assign rsp_o.head_priority = out_head_prio_q;

  for (genvar i = 0; i < CAPACITY - 1; i++) begin : g_order
    assign order_ok[i] = !occ[i+1] ||
                         !($signed(cell_q[i].prio) < $signed(cell_q[i+1].prio));
  end

  `SPQ_ASSERT(a_count_bound, count_q <= CountW'(CAPACITY), "entry count above capacity")
  `SPQ_ASSERT(a_sorted, &order_ok, "stored entries out of priority order")
  `SPQ_ASSERT(a_reinsert_out_free, (state_q != ST_REINSERT) || !out_valid_q,
              "result pending during reinsert")
  `SPQ_ASSERT_NEXT(a_count_step, 1'b1,
                   (count_q == $past(count_q)) ||
                   (count_q == $past(count_q) + CountW'(1)) ||
                   (count_q + CountW'(1) == $past(count_q)),
                   "entry count moved by more than one")

endmodule
